/* hdl/csvt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Beat types, configuration layout, opcodes and status codes shared by the
// tokenizer modules.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_EOL   = 2'd1;
  localparam logic [1:0] OP_SOF   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_DELIM = 2'd1;
  localparam logic [1:0] ST_COUNT    = 2'd2;
  localparam logic [1:0] ST_HALTED   = 2'd3;

  localparam logic [1:0] REG_FIELD_DELIM  = 2'd0;
  localparam logic [1:0] REG_QUOTE_CHAR   = 2'd1;
  localparam logic [1:0] REG_ENFORCE      = 2'd2;
  localparam logic [1:0] REG_FIRST_HEADER = 2'd3;

  localparam logic [7:0] DEF_DELIM = 8'd44;
  localparam logic [7:0] DEF_QUOTE = 8'd34;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] in_byte;
  } csvt_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       line_end;
    logic       header_line;
    logic [7:0] fields_so_far;
    logic [1:0] status;
  } csvt_out_t;

  typedef struct packed {
    logic [7:0] field_delim;
    logic [7:0] quote_char;
    logic       enforce_same_count;
    logic       first_line_header;
  } csvt_cfg_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data;
    logic       is_ws;
    logic       is_delim;
    logic       is_quote;
  } csvt_cls_t;

endpackage : csvt_pkg
`default_nettype wire

/* hdl/csv_field_tokenizer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// CSV field tokenizer core
// Byte-serial CSV tokenizer with quoting, field and line marks and a
// per-line field count check.
//
//   Channel   Direction  Beat contents
//   in_       input      opcode, in_byte
//   out_      output     out_byte, byte_valid, field_end, line_end,
//                        header_line, fields_so_far, status
//   cfg_      input      register index, write data
//
// One beat is accepted and one result produced every cycle while out_ready is high.
// A beat passes through the classify register, the queue and the result
// register of the parse state machine, which updates once per beat.
// Reset loads the register defaults and clears the parse state.
// A four-entry queue lets the front end keep accepting while the result
// side stalls.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_core #(
  parameter int MAX_FIELDS = 255
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  csvt_pkg::csvt_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output csvt_pkg::csvt_out_t  out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [1:0]            cfg_index,
  input  wire [7:0]            cfg_data
);
  import csvt_pkg::*;

  localparam int         CAP_INT   = (MAX_FIELDS < 255) ? MAX_FIELDS : 255;
  localparam logic [7:0] FIELD_CAP = CAP_INT[7:0];

  csvt_cfg_t cfg_r;
  logic      f_valid;
  logic      f_ready;
  csvt_cls_t f_data;
  logic      q_valid;
  logic      q_ready;
  csvt_cls_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.field_delim        <= DEF_DELIM;
      cfg_r.quote_char         <= DEF_QUOTE;
      cfg_r.enforce_same_count <= 1'b1;
      cfg_r.first_line_header  <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIELD_DELIM:  cfg_r.field_delim        <= cfg_data;
        REG_QUOTE_CHAR:   cfg_r.quote_char         <= cfg_data;
        REG_ENFORCE:      cfg_r.enforce_same_count <= cfg_data[0];
        REG_FIRST_HEADER: cfg_r.first_line_header  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  csvt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .cls_valid (f_valid),
    .cls_ready (f_ready),
    .cls_data  (f_data)
  );

  csvt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  csvt_back #(
    .FIELD_CAP (FIELD_CAP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (q_valid),
    .cls_ready (q_ready),
    .cls_data  (q_data),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule : csv_field_tokenizer_core
`default_nettype wire

/* hdl/csvt_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// CSV tokenizer front end
// Accepts input beats and registers each byte with its character class.
// ----------------------------------------------------------------------------
module csvt_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  csvt_pkg::csvt_in_t   in_data,
  input  csvt_pkg::csvt_cfg_t  cfg,
  output logic                 cls_valid,
  input  wire                  cls_ready,
  output csvt_pkg::csvt_cls_t  cls_data
);
  import csvt_pkg::*;

  logic      vld_r;
  csvt_cls_t cls_r;
  csvt_cls_t cls_nxt;

  assign in_ready  = !vld_r || cls_ready;
  assign cls_valid = vld_r;
  assign cls_data  = cls_r;

  always_comb begin
    cls_nxt.opcode   = in_data.opcode;
    cls_nxt.data     = in_data.in_byte;
    cls_nxt.is_ws    = (in_data.in_byte == 8'd32) ||
                       (in_data.in_byte inside {[8'd9:8'd13]});
    cls_nxt.is_delim = (in_data.in_byte == cfg.field_delim);
    cls_nxt.is_quote = (in_data.in_byte == cfg.quote_char);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cls_r <= cls_nxt;
    end
  end

endmodule : csvt_front
`default_nettype wire

/* hdl/csvt_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// CSV tokenizer queue
// Four-entry queue of classified beats between the front and back ends.
// ----------------------------------------------------------------------------
module csvt_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push_valid,
  output logic                 push_ready,
  input  csvt_pkg::csvt_cls_t  push_data,
  output logic                 pop_valid,
  input  wire                  pop_ready,
  output csvt_pkg::csvt_cls_t  pop_data
);
  import csvt_pkg::*;

  csvt_cls_t  mem_r [4];
  logic [1:0] wr_ptr_r;
  logic [1:0] rd_ptr_r;
  logic [2:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 3'd4);
  assign pop_valid  = (count_r != 3'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 3'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : csvt_queue
`default_nettype wire

/* hdl/csvt_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// CSV tokenizer back end
// Parse state machine, field counting and line checks, with a result register.
// ----------------------------------------------------------------------------
module csvt_back #(
  parameter logic [7:0] FIELD_CAP = 8'd255
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cls_valid,
  output logic                 cls_ready,
  input  csvt_pkg::csvt_cls_t  cls_data,
  input  csvt_pkg::csvt_cfg_t  cfg,
  output logic                 out_valid,
  input  wire                  out_ready,
  output csvt_pkg::csvt_out_t  out_data
);
  import csvt_pkg::*;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_PLAIN  = 2'd1,
    PH_QUOTED = 2'd2,
    PH_AFTERQ = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] line_fields_r, line_fields_nxt;
  logic [7:0] prev_fields_r, prev_fields_nxt;
  logic       have_prev_r, have_prev_nxt;
  logic       first_line_r, first_line_nxt;
  logic       halted_r, halted_nxt;
  logic       out_valid_r;
  csvt_out_t  out_r, out_nxt;
  logic       take;
  logic [7:0] lf_inc;

  assign cls_ready = !out_valid_r || out_ready;
  assign take      = cls_valid && cls_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign lf_inc    = (line_fields_r < FIELD_CAP) ? line_fields_r + 8'd1 : line_fields_r;

  always_comb begin
    phase_nxt       = phase_r;
    line_fields_nxt = line_fields_r;
    prev_fields_nxt = prev_fields_r;
    have_prev_nxt   = have_prev_r;
    first_line_nxt  = first_line_r;
    halted_nxt      = halted_r;
    out_nxt         = '0;
    if (cls_data.opcode == OP_SOF) begin
      phase_nxt       = PH_START;
      line_fields_nxt = 8'd0;
      prev_fields_nxt = 8'd0;
      have_prev_nxt   = 1'b0;
      first_line_nxt  = 1'b1;
      halted_nxt      = 1'b0;
    end else if (halted_r) begin
      out_nxt.status = ST_HALTED;
    end else if (cls_data.opcode == OP_DATA) begin
      out_nxt.header_line = cfg.first_line_header && first_line_r;
      case (phase_r)
        PH_START: begin
          if (cls_data.is_ws) begin
          end else if (cls_data.is_delim) begin
            line_fields_nxt   = lf_inc;
            out_nxt.field_end = 1'b1;
          end else if (cls_data.is_quote) begin
            phase_nxt = PH_QUOTED;
          end else begin
            phase_nxt          = PH_PLAIN;
            out_nxt.out_byte   = cls_data.data;
            out_nxt.byte_valid = 1'b1;
          end
        end
        PH_PLAIN: begin
          if (cls_data.is_delim) begin
            line_fields_nxt   = lf_inc;
            out_nxt.field_end = 1'b1;
            phase_nxt         = PH_START;
          end else begin
            out_nxt.out_byte   = cls_data.data;
            out_nxt.byte_valid = 1'b1;
          end
        end
        PH_QUOTED: begin
          if (cls_data.is_quote) begin
            line_fields_nxt   = lf_inc;
            out_nxt.field_end = 1'b1;
            phase_nxt         = PH_AFTERQ;
          end else begin
            out_nxt.out_byte   = cls_data.data;
            out_nxt.byte_valid = 1'b1;
          end
        end
        default: begin
          if (cls_data.is_ws) begin
          end else if (cls_data.is_delim) begin
            phase_nxt = PH_START;
          end else begin
            out_nxt.status = ST_NO_DELIM;
            halted_nxt     = 1'b1;
          end
        end
      endcase
      out_nxt.fields_so_far = line_fields_nxt;
    end else if (cls_data.opcode == OP_EOL) begin
      out_nxt.header_line = cfg.first_line_header && first_line_r;
      if (phase_r != PH_AFTERQ) begin
        line_fields_nxt   = lf_inc;
        out_nxt.field_end = 1'b1;
      end
      out_nxt.fields_so_far = line_fields_nxt;
      if (cfg.enforce_same_count && have_prev_r && (prev_fields_r != line_fields_nxt)) begin
        out_nxt.status    = ST_COUNT;
        out_nxt.field_end = 1'b0;
        halted_nxt        = 1'b1;
      end else begin
        out_nxt.line_end = 1'b1;
        prev_fields_nxt  = line_fields_nxt;
        have_prev_nxt    = 1'b1;
        first_line_nxt   = 1'b0;
        line_fields_nxt  = 8'd0;
        phase_nxt        = PH_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_START;
      line_fields_r <= 8'd0;
      prev_fields_r <= 8'd0;
      have_prev_r   <= 1'b0;
      first_line_r  <= 1'b1;
      halted_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cls_ready) begin
        out_valid_r <= cls_valid;
      end
      if (take) begin
        phase_r       <= phase_nxt;
        line_fields_r <= line_fields_nxt;
        prev_fields_r <= prev_fields_nxt;
        have_prev_r   <= have_prev_nxt;
        first_line_r  <= first_line_nxt;
        halted_r      <= halted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

endmodule : csvt_back
`default_nettype wire
